// ===== rtl/pbsr_pkg.sv =====
// ----------------------------------------------------------------------------
// pbsr_pkg
// Shared widths and codes for the position binned sensor recorder.
// ----------------------------------------------------------------------------
package pbsr_pkg;

	localparam int VAL_W = 10;
	localparam int POS_W = 32;
	localparam int REV_W = 31;
	localparam int PER_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_RECORD_ENABLE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_REVOLUTION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLE_PERIOD    = 2'd2;

	// item operations
	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

endpackage

// ===== rtl/pbsr_if.sv =====
// ----------------------------------------------------------------------------
// pbsr_if
// Valid/ready channels: input items, result items, configuration writes.
// ----------------------------------------------------------------------------
interface pbsr_item_if;
	logic                            valid;
	logic                            ready;
	logic                            operation;
	logic signed [pbsr_pkg::POS_W-1:0] absolute_pos;
	logic [pbsr_pkg::VAL_W-1:0]      sample;
	logic [pbsr_pkg::VAL_W-1:0]      query_value;
	modport source (output valid, operation, absolute_pos, sample, query_value, input ready);
	modport sink (input valid, operation, absolute_pos, sample, query_value, output ready);
endinterface

interface pbsr_result_if;
	logic                            valid;
	logic                            ready;
	logic [pbsr_pkg::VAL_W-1:0]      current_value;
	logic                            refreshed;
	logic signed [pbsr_pkg::POS_W-1:0] found_position;
	modport source (output valid, current_value, refreshed, found_position, input ready);
	modport sink (input valid, current_value, refreshed, found_position, output ready);
endinterface

interface pbsr_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [pbsr_pkg::CFG_IDX_W-1:0]    index;
	logic [pbsr_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/pbsr_div.sv =====
// ----------------------------------------------------------------------------
// pbsr_div
// Unsigned 32/32 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbsr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quot
);

	logic [31:0] den_q;
	logic [31:0] nq_q;   // numerator shifts out, quotient shifts in
	logic [31:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic        ge;

	assign trial = {rem_q, nq_q[31]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			nq_q  <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			nq_q  <= {nq_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign quot = nq_q;

endmodule

// ===== rtl/pbsr_tables.sv =====
// ----------------------------------------------------------------------------
// pbsr_tables
// Value and position tables: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pbsr_tables #(
	parameter int SLOTS = 256
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [$clog2(SLOTS)-1:0]            waddr,
	input  logic [pbsr_pkg::VAL_W-1:0]          wval,
	input  logic [pbsr_pkg::POS_W-1:0]          wpos,
	input  logic [$clog2(SLOTS)-1:0]            raddr,
	output logic [pbsr_pkg::VAL_W-1:0]          rval,
	output logic [pbsr_pkg::POS_W-1:0]          rpos
);

	logic [pbsr_pkg::VAL_W-1:0] val_mem [SLOTS];
	logic [pbsr_pkg::POS_W-1:0] pos_mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			val_mem[waddr] <= wval;
			pos_mem[waddr] <= wpos;
		end
		rval <= val_mem[raddr];
		rpos <= pos_mem[raddr];
	end

endmodule

// ===== rtl/position_binned_sensor_recorder.sv =====
// ----------------------------------------------------------------------------
// position_binned_sensor_recorder
// Records filtered sensor samples by shaft position, plays them back, and
// finds the position of the stored value nearest a query.
// ----------------------------------------------------------------------------
// After reset the block clears its tables and filter ring and accepts no item
// until the clearing pass is done. One item is in work at a time; the input is
// ready again the cycle after a result is loaded. A tick that does not fire the
// divider goes straight to its result. A fired tick that records passes through
// the step, ring, sum and average states; slot width and filter average come
// from constant reciprocal multiplies. A fired tick that plays back reads its
// slot at once when the slot width is zero or the position is not positive,
// else the slot index is first found by dividing the position by the slot
// width. A lookup scans the value table through its single read port. A stalled
// result port holds the item in its last cycle until the output register frees.
// A finished result waits in the output register while the next item is taken.
module position_binned_sensor_recorder #(
	parameter int SLOTS       = 256,
	parameter int FILTER_TAPS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	pbsr_item_if.sink      item,
	pbsr_result_if.source  result,
	pbsr_cfg_if.sink       cfg
);

	localparam int SW   = $clog2(SLOTS);
	localparam int RSW  = $clog2(SLOTS + 1);
	localparam int RW   = (FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 1;
	localparam int SUMW = pbsr_pkg::VAL_W + RW;
	localparam int CLRN = (SLOTS > FILTER_TAPS) ? SLOTS : FILTER_TAPS;
	localparam int CW   = $clog2(CLRN);
	localparam int CW1  = CW + 1;
	localparam int PW   = pbsr_pkg::REV_W + RSW;

	// floor(n / d) == (n * ceil(2^s / d)) >> s for n < 2^w, s = w + ceil(log2 d)
	localparam int STEP_SH = pbsr_pkg::REV_W + SW;
	localparam int SMW     = pbsr_pkg::REV_W + 33;
	localparam longint unsigned STEP_MUL =
		((64'd1 << STEP_SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
	localparam int AVG_SH  = SUMW + RW;
	localparam int AMW     = SUMW + AVG_SH + 1;
	localparam longint unsigned AVG_MUL =
		((64'd1 << AVG_SH) + 64'(FILTER_TAPS) - 64'd1) / 64'(FILTER_TAPS);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_STEP   = 4'd1;
	localparam logic [3:0] ST_RING   = 4'd2;
	localparam logic [3:0] ST_SUM    = 4'd3;
	localparam logic [3:0] ST_AVG    = 4'd4;
	localparam logic [3:0] ST_PB_DIV = 4'd5;
	localparam logic [3:0] ST_PB_RD  = 4'd6;
	localparam logic [3:0] ST_PB_WT  = 4'd7;
	localparam logic [3:0] ST_LK     = 4'd8;
	localparam logic [3:0] ST_LK_DR  = 4'd9;
	localparam logic [3:0] ST_LK_RD  = 4'd10;
	localparam logic [3:0] ST_LK_WT  = 4'd11;
	localparam logic [3:0] ST_DONE   = 4'd12;

	// configuration
	logic                          rec_en_q;
	logic [pbsr_pkg::REV_W-1:0]    full_rev_q;
	logic [pbsr_pkg::PER_W-1:0]    period_q;

	// block state
	logic [3:0]                    state_q;
	logic [pbsr_pkg::PER_W-1:0]    tick_q;
	logic [RW-1:0]                 fslot_q;
	logic [RSW-1:0]                rslot_q;
	logic [SUMW-1:0]               sum_q;
	logic [pbsr_pkg::VAL_W-1:0]    latest_q;
	logic                          clr_busy_q;
	logic [CW-1:0]                 clr_cnt_q;

	// item in work
	logic [pbsr_pkg::POS_W-1:0]    pos_q;
	logic [pbsr_pkg::VAL_W-1:0]    sample_q;
	logic [pbsr_pkg::VAL_W-1:0]    query_q;
	logic                          fired_q;
	logic [pbsr_pkg::POS_W-1:0]    found_q;
	logic [pbsr_pkg::REV_W-1:0]    step_q;
	logic [PW-1:0]                 prod_q;
	logic [SW-1:0]                 pb_idx_q;

	// lookup scan
	logic [SW-1:0]                 lk_cnt_q;
	logic                          lk_v_s1;
	logic [SW-1:0]                 lk_idx_s1;
	logic [SW-1:0]                 best_q;
	logic [pbsr_pkg::VAL_W:0]      best_d_q;

	// filter ring
	logic [pbsr_pkg::VAL_W-1:0]    ring_mem [FILTER_TAPS];
	logic [pbsr_pkg::VAL_W-1:0]    ring_rd_q;

	// output register
	logic                          out_v_q;
	logic [pbsr_pkg::VAL_W-1:0]    out_val_q;
	logic                          out_ref_q;
	logic [pbsr_pkg::POS_W-1:0]    out_pos_q;

	// divider and tables
	logic                          div_start;
	logic [31:0]                   div_num;
	logic [31:0]                   div_den;
	logic                          div_done;
	logic [31:0]                   div_quot;
	logic                          tb_we;
	logic [SW-1:0]                 tb_waddr;
	logic [pbsr_pkg::VAL_W-1:0]    tb_wval;
	logic [pbsr_pkg::POS_W-1:0]    tb_wpos;
	logic [SW-1:0]                 tb_raddr;
	logic [pbsr_pkg::VAL_W-1:0]    tb_rval;
	logic [pbsr_pkg::POS_W-1:0]    tb_rpos;

	logic                          accept;
	logic                          fire;
	logic [SUMW-1:0]               new_sum;
	logic                          advance;
	logic [RSW-1:0]                next_rslot;
	logic [pbsr_pkg::VAL_W-1:0]    avg;
	logic [AMW-1:0]                avg_prod;
	logic [SMW-1:0]                step_prod;
	logic [pbsr_pkg::REV_W-1:0]    step_c;
	logic [pbsr_pkg::VAL_W:0]      lk_d;
	logic                          out_free;

	assign item.ready = (state_q == ST_IDLE) && !clr_busy_q;
	assign accept     = item.valid && item.ready;
	assign fire       = tick_q >= period_q;
	assign cfg.ready  = 1'b1;
	assign out_free   = !out_v_q || result.ready;

	assign step_prod  = SMW'(full_rev_q) * SMW'(STEP_MUL);
	assign step_c     = pbsr_pkg::REV_W'(step_prod >> STEP_SH);
	assign avg_prod   = AMW'(sum_q) * AMW'(AVG_MUL);
	assign avg        = pbsr_pkg::VAL_W'(avg_prod >> AVG_SH);

	assign new_sum    = SUMW'(sum_q - SUMW'(ring_rd_q) + SUMW'(sample_q));
	assign advance    = !pos_q[31] && ({{(PW-31){1'b0}}, pos_q[30:0]} > prod_q);
	assign next_rslot = advance ? RSW'(rslot_q + RSW'(1)) : rslot_q;
	assign lk_d       = (tb_rval > query_q) ? {1'b0, tb_rval - query_q}
	                                        : {1'b0, query_q - tb_rval};

	pbsr_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	pbsr_tables #(.SLOTS(SLOTS)) u_tables (
		.clk  (clk),
		.we   (tb_we),
		.waddr(tb_waddr),
		.wval (tb_wval),
		.wpos (tb_wpos),
		.raddr(tb_raddr),
		.rval (tb_rval),
		.rpos (tb_rpos)
	);

	// playback slot index: position over slot width
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		if (state_q == ST_STEP && !(rec_en_q && rslot_q < RSW'(SLOTS))
		    && step_q != '0 && !pos_q[31] && pos_q != '0) begin
			div_start = 1'b1;
			div_num   = pos_q;
			div_den   = {1'b0, step_q};
		end
	end

	// table port selection
	always_comb begin
		tb_we    = 1'b0;
		tb_waddr = '0;
		tb_wval  = '0;
		tb_wpos  = '0;
		tb_raddr = '0;
		if (clr_busy_q) begin
			tb_we    = {1'b0, clr_cnt_q} < CW1'(SLOTS);
			tb_waddr = clr_cnt_q[SW-1:0];
		end else if (state_q == ST_AVG && next_rslot < RSW'(SLOTS)) begin
			tb_we    = 1'b1;
			tb_waddr = next_rslot[SW-1:0];
			tb_wval  = avg;
			tb_wpos  = pos_q;
		end
		unique case (state_q)
			ST_PB_RD: tb_raddr = pb_idx_q;
			ST_LK:    tb_raddr = lk_cnt_q;
			ST_LK_RD: tb_raddr = best_q;
			default:  tb_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_en_q <= 1'b0;
			full_rev_q <= pbsr_pkg::REV_W'(25600);
			period_q <= pbsr_pkg::PER_W'(10);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pbsr_pkg::REG_RECORD_ENABLE:   rec_en_q   <= cfg.data[0];
				pbsr_pkg::REG_FULL_REVOLUTION: full_rev_q <= cfg.data[pbsr_pkg::REV_W-1:0];
				pbsr_pkg::REG_CYCLE_PERIOD:    period_q   <= cfg.data[pbsr_pkg::PER_W-1:0];
				default: ;
			endcase
		end
	end

	// ring memory: clearing pass, write, registered read
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			if ({1'b0, clr_cnt_q} < CW1'(FILTER_TAPS))
				ring_mem[clr_cnt_q[RW-1:0]] <= '0;
		end else if (state_q == ST_SUM) begin
			ring_mem[fslot_q] <= sample_q;
		end
		ring_rd_q <= ring_mem[fslot_q];
	end

	// sequencer and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tick_q     <= '0;
			fslot_q    <= '0;
			rslot_q    <= '0;
			sum_q      <= '0;
			latest_q   <= '0;
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
			lk_v_s1    <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= CW'(clr_cnt_q + CW'(1));
				if (clr_cnt_q == CW'(CLRN - 1))
					clr_busy_q <= 1'b0;
			end
			if (state_q == ST_DONE && out_free)
				out_v_q <= 1'b1;
			else if (result.ready)
				out_v_q <= 1'b0;
			lk_v_s1 <= (state_q == ST_LK);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.operation == pbsr_pkg::OP_LOOKUP) begin
							state_q <= ST_LK;
						end else if (fire) begin
							tick_q  <= '0;
							state_q <= ST_STEP;
						end else begin
							tick_q  <= pbsr_pkg::PER_W'(tick_q + 1'b1);
							state_q <= ST_DONE;
						end
					end
				end
				ST_STEP: begin
					if (rec_en_q && rslot_q < RSW'(SLOTS))
						state_q <= ST_RING;
					else if (step_q == '0 || pos_q[31] || pos_q == '0)
						state_q <= ST_PB_RD;
					else
						state_q <= ST_PB_DIV;
				end
				ST_RING: state_q <= ST_SUM;
				ST_SUM: begin
					sum_q   <= new_sum;
					fslot_q <= (fslot_q == RW'(FILTER_TAPS - 1)) ? '0 : RW'(fslot_q + 1'b1);
					state_q <= ST_AVG;
				end
				ST_AVG: begin
					latest_q <= avg;
					rslot_q  <= next_rslot;
					state_q  <= ST_DONE;
				end
				ST_PB_DIV: if (div_done) state_q <= ST_PB_RD;
				ST_PB_RD:  state_q <= ST_PB_WT;
				ST_PB_WT: begin
					latest_q <= tb_rval;
					state_q  <= ST_DONE;
				end
				ST_LK: begin
					if (lk_cnt_q == SW'(SLOTS - 1))
						state_q <= ST_LK_DR;
				end
				ST_LK_DR: state_q <= ST_LK_RD;
				ST_LK_RD: state_q <= ST_LK_WT;
				ST_LK_WT: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload and work registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q    <= item.absolute_pos;
			sample_q <= item.sample;
			query_q  <= item.query_value;
			fired_q  <= item.operation == pbsr_pkg::OP_TICK && fire;
			found_q  <= '0;
			lk_cnt_q <= '0;
			best_q   <= '0;
			best_d_q <= '1;
			step_q   <= step_c;
		end
		if (state_q == ST_STEP) begin
			// zero step plays back the last slot; non-positive positions slot 0
			pb_idx_q <= (step_q == '0) ? SW'(SLOTS - 1) : '0;
		end
		if (state_q == ST_RING)
			prod_q <= PW'(step_q * PW'(rslot_q + RSW'(1)));
		if (state_q == ST_PB_DIV && div_done)
			pb_idx_q <= (div_quot > 32'(SLOTS - 1)) ? SW'(SLOTS - 1) : div_quot[SW-1:0];
		if (state_q == ST_LK) begin
			lk_cnt_q  <= SW'(lk_cnt_q + 1'b1);
			lk_idx_s1 <= lk_cnt_q;
		end
		// strict compare keeps the lowest slot on ties
		if (lk_v_s1 && lk_d < best_d_q) begin
			best_d_q <= lk_d;
			best_q   <= lk_idx_s1;
		end
		if (state_q == ST_LK_WT)
			found_q <= tb_rpos;
		if (state_q == ST_DONE && out_free) begin
			out_val_q <= latest_q;
			out_ref_q <= fired_q;
			out_pos_q <= found_q;
		end
	end

	assign result.valid          = out_v_q;
	assign result.current_value  = out_val_q;
	assign result.refreshed      = out_ref_q;
	assign result.found_position = out_pos_q;

endmodule

// ===== verif/recorder_checker.sv =====
// ----------------------------------------------------------------------------
// recorder_checker
// Watches the item, result and configuration channels of the recorder. Keeps
// its own copy of the tables, filter and divider, predicts one result per
// accepted item and compares it, field by field, with the result beats.
// ----------------------------------------------------------------------------
module recorder_checker (
	input  logic   clk,
	input  logic   arst_n,
	pbsr_item_if   item,
	pbsr_result_if result,
	pbsr_cfg_if    cfg,
	output int     errors,
	output int     pending
);

	localparam int NSLOT = 256;
	localparam int TAPS  = 8;

	typedef struct {
		logic [pbsr_pkg::VAL_W-1:0]        value;
		logic                              fired;
		logic signed [pbsr_pkg::POS_W-1:0] pos;
	} result_t;

	result_t expected_results[$];

	logic                       rec_en;
	logic [pbsr_pkg::REV_W-1:0] rev;
	logic [pbsr_pkg::PER_W-1:0] period;

	logic [pbsr_pkg::PER_W-1:0]        ticks;
	logic [pbsr_pkg::VAL_W-1:0]        ring[TAPS];
	int                                ring_slot;
	int                                rec_slot;
	logic [pbsr_pkg::VAL_W-1:0]        values[NSLOT];
	logic signed [pbsr_pkg::POS_W-1:0] positions[NSLOT];
	logic [pbsr_pkg::VAL_W-1:0]        latest;

	function automatic logic signed [pbsr_pkg::POS_W-1:0] nearest_position(
			logic [pbsr_pkg::VAL_W-1:0] q);
		int best;
		int bestd;
		int d;
		best = 0;
		bestd = 1 << 20;
		for (int c = 0; c < NSLOT; c++) begin
			d = (values[c] > q) ? int'(values[c]) - int'(q) : int'(q) - int'(values[c]);
			if (d < bestd) begin
				bestd = d;
				best = c;
			end
		end
		return positions[best];
	endfunction

	// advances the model by one item and returns the result it causes
	function automatic result_t predict_item(logic op, logic signed [pbsr_pkg::POS_W-1:0] pos,
			logic [pbsr_pkg::VAL_W-1:0] samp, logic [pbsr_pkg::VAL_W-1:0] q);
		result_t r;
		longint step;
		longint idx;
		int sum;
		r.fired = 1'b0;
		r.pos = '0;
		step = longint'(rev / NSLOT);
		if (op == pbsr_pkg::OP_LOOKUP) begin
			r.pos = nearest_position(q);
		end else if (ticks < period) begin
			ticks = ticks + 1'b1;
		end else begin
			ticks = '0;
			r.fired = 1'b1;
			if (rec_en && rec_slot < NSLOT) begin
				ring[ring_slot] = samp;
				ring_slot = (ring_slot + 1 >= TAPS) ? 0 : ring_slot + 1;
				sum = 0;
				for (int i = 0; i < TAPS; i++)
					sum += ring[i];
				latest = pbsr_pkg::VAL_W'(sum / TAPS);
				if (longint'(pos) > step * (rec_slot + 1))
					rec_slot++;
				if (rec_slot < NSLOT) begin
					positions[rec_slot] = pos;
					values[rec_slot] = latest;
				end
			end else begin
				// zero step plays back from the top slot
				idx = (step == 0) ? NSLOT - 1 : longint'(pos) / step;
				if (idx < 0)
					idx = 0;
				if (idx > NSLOT - 1)
					idx = NSLOT - 1;
				latest = values[idx];
			end
		end
		r.value = latest;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			rec_en = 1'b0;
			rev = 31'd25600;
			period = 16'd10;
			ticks = '0;
			ring_slot = 0;
			rec_slot = 0;
			latest = '0;
			for (int i = 0; i < TAPS; i++)
				ring[i] = '0;
			for (int i = 0; i < NSLOT; i++) begin
				values[i] = '0;
				positions[i] = '0;
			end
			expected_results.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					pbsr_pkg::REG_RECORD_ENABLE: rec_en = cfg.data[0];
					pbsr_pkg::REG_FULL_REVOLUTION: rev = cfg.data[pbsr_pkg::REV_W-1:0];
					pbsr_pkg::REG_CYCLE_PERIOD: period = cfg.data[pbsr_pkg::PER_W-1:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat value=%0d refreshed=%0b pos=%0d",
						$time, result.current_value, result.refreshed, result.found_position);
				end else begin
					e = expected_results.pop_front();
					if (result.current_value !== e.value) begin
						errors++;
						$display("%0t: current_value expected %0d actual %0d",
							$time, e.value, result.current_value);
					end
					if (result.refreshed !== e.fired) begin
						errors++;
						$display("%0t: refreshed expected %0b actual %0b",
							$time, e.fired, result.refreshed);
					end
					if (result.found_position !== e.pos) begin
						errors++;
						$display("%0t: found_position expected %0d actual %0d",
							$time, e.pos, result.found_position);
					end
				end
			end
			if (item.valid && item.ready)
				expected_results.push_back(predict_item(item.operation, item.absolute_pos,
					item.sample, item.query_value));
			pending = expected_results.size();
		end
	end

endmodule

// ===== verif/position_binned_sensor_recorder_tb.sv =====
// ----------------------------------------------------------------------------
// position_binned_sensor_recorder_tb
// Drives the recorder with directed and random tick and lookup beats under
// several register settings, with random gaps and result stalls; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module position_binned_sensor_recorder_tb;

	localparam int LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic quiet;
	int   errors;
	int   pending;
	int   cycles;
	int   stall;
	longint walk;

	pbsr_item_if   item ();
	pbsr_result_if result ();
	pbsr_cfg_if    cfg ();

	position_binned_sensor_recorder DUT (
		.clk(clk), .arst_n(arst_n), .item(item), .result(result), .cfg(cfg)
	);

	recorder_checker checker_i (
		.clk(clk), .arst_n(arst_n), .item(item), .result(result), .cfg(cfg),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result side back-pressure in bursts
	always @(negedge clk) begin
		if (quiet || !arst_n) begin
			result.ready <= 1'b1;
		end else if (stall > 0) begin
			stall <= stall - 1;
			result.ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall <= $urandom_range(1, 19) - 1;
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
		end
	end

	// leaves valid high; the caller lowers it with cfg_release
	task automatic cfg_write(logic [pbsr_pkg::CFG_IDX_W-1:0] idx,
			logic [pbsr_pkg::CFG_DATA_W-1:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic cfg_release();
		cfg.valid <= 1'b0;
	endtask

	task automatic send(logic op, logic signed [pbsr_pkg::POS_W-1:0] pos,
			logic [pbsr_pkg::VAL_W-1:0] samp, logic [pbsr_pkg::VAL_W-1:0] q);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(1, 19))
				@(negedge clk);
		end
		item.valid <= 1'b1;
		item.operation <= op;
		item.absolute_pos <= pos;
		item.sample <= samp;
		item.query_value <= q;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		item.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8)
			@(negedge clk);
	endtask

	task automatic configure(logic en, logic [pbsr_pkg::REV_W-1:0] rv,
			logic [pbsr_pkg::PER_W-1:0] per);
		drain();
		cfg_write(pbsr_pkg::REG_RECORD_ENABLE, 32'(en));
		cfg_write(pbsr_pkg::REG_FULL_REVOLUTION, 32'(rv));
		cfg_write(pbsr_pkg::REG_CYCLE_PERIOD, 32'(per));
		cfg_release();
	endtask

	task automatic random_phase(int n, logic [pbsr_pkg::REV_W-1:0] rv);
		int r;
		longint step;
		step = longint'(rv / 256);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				send(pbsr_pkg::OP_LOOKUP, $urandom, 10'($urandom), 10'($urandom));
			end else if (r < 25) begin
				send(pbsr_pkg::OP_TICK, $urandom, 10'($urandom), 10'($urandom));
			end else begin
				walk += longint'($urandom_range(0, 32'(2 * step + 2)));
				if (walk > 64'sh7fffffff)
					walk = -longint'($urandom_range(0, 50));
				send(pbsr_pkg::OP_TICK, 32'(walk), 10'($urandom), 10'($urandom));
			end
		end
	endtask

	initial begin
		logic [pbsr_pkg::REV_W-1:0] rv;
		quiet = 1'b0;
		cycles = 0;
		stall = 0;
		walk = 0;
		arst_n = 1'b0;
		item.valid = 1'b0;
		item.operation = pbsr_pkg::OP_TICK;
		item.absolute_pos = '0;
		item.sample = '0;
		item.query_value = '0;
		cfg.valid = 1'b0;
		cfg.index = pbsr_pkg::REG_RECORD_ENABLE;
		cfg.data = '0;
		result.ready = 1'b1;
		repeat (10)
			@(negedge clk);
		arst_n = 1'b1;

		// reset settings: divider holds off for ten ticks, then plays back
		send(pbsr_pkg::OP_LOOKUP, 0, 0, 10'd1023);
		for (int i = 0; i < 11; i++)
			send(pbsr_pkg::OP_TICK, 500, 10'd1023, 0);

		// recording, step 100, fire every tick
		configure(1'b1, 31'd25600, 16'd0);
		send(pbsr_pkg::OP_TICK, -32'sd5, 10'd1023, 0);
		send(pbsr_pkg::OP_TICK, 50, 10'd0, 0);
		send(pbsr_pkg::OP_TICK, 150, 10'd1023, 0);
		send(pbsr_pkg::OP_TICK, 32'sh7fffffff, 10'd1023, 0);
		send(pbsr_pkg::OP_TICK, 32'sh80000000, 10'd512, 0);
		send(pbsr_pkg::OP_LOOKUP, 0, 0, 10'd0);
		send(pbsr_pkg::OP_LOOKUP, 0, 0, 10'd1023);
		send(pbsr_pkg::OP_LOOKUP, 0, 0, 10'd255);

		// playback, every second tick fires: in range and beyond the table; the negative tick does not fire
		configure(1'b0, 31'd25600, 16'd1);
		send(pbsr_pkg::OP_TICK, 32'sh80000000, 0, 0);
		send(pbsr_pkg::OP_TICK, 150, 0, 0);
		send(pbsr_pkg::OP_TICK, 250, 0, 0);
		send(pbsr_pkg::OP_TICK, 32'sh7fffffff, 0, 0);

		// zero step and smallest revolution
		configure(1'b0, 31'd1, 16'd0);
		send(pbsr_pkg::OP_TICK, 42, 0, 0);
		configure(1'b1, 31'd255, 16'd0);
		send(pbsr_pkg::OP_TICK, 0, 10'd100, 0);
		send(pbsr_pkg::OP_TICK, 1, 10'd200, 0);

		// tick count left above a lowered period fires at once
		configure(1'b0, 31'h7fffffff, 16'hffff);
		for (int i = 0; i < 3; i++)
			send(pbsr_pkg::OP_TICK, $urandom, 0, 0);
		configure(1'b0, 31'h7fffffff, 16'd0);
		send(pbsr_pkg::OP_TICK, 32'sh7fffffff, 0, 0);

		// random part
		configure(1'b1, 31'd25600, 16'd0);
		random_phase(150, 31'd25600);
		configure(1'b0, 31'd25600, 16'd1);
		random_phase(100, 31'd25600);
		walk = 0;
		configure(1'b1, 31'd100, 16'd0);
		random_phase(60, 31'd100);
		configure(1'b0, 31'd100, 16'd2);
		random_phase(60, 31'd100);
		walk = -3;
		configure(1'b1, 31'h7fffffff, 16'd0);
		random_phase(80, 31'h7fffffff);
		rv = pbsr_pkg::REV_W'($urandom_range(1, 32'h7fffffff));
		configure(1'b0, rv, 16'($urandom_range(0, 3)));
		random_phase(100, rv);
		rv = pbsr_pkg::REV_W'($urandom_range(256, 200000));
		walk = 0;
		configure(1'b1, rv, 16'd0);
		random_phase(120, rv);
		drain();
		quiet = 1'b1;
		configure(1'b0, 31'd25600, 16'd0);
		random_phase(120, 31'd25600);

		drain();
		repeat (300)
			@(negedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== position_binned_sensor_recorder.f =====
rtl/pbsr_pkg.sv
rtl/pbsr_if.sv
rtl/pbsr_div.sv
rtl/pbsr_tables.sv
rtl/position_binned_sensor_recorder.sv
verif/recorder_checker.sv
verif/position_binned_sensor_recorder_tb.sv
